FILE: rtl/core/lmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants of the 3x3 local minimum counter.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int VAL_W       = 32;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CNT_W       = 21;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0]        t_count;

    localparam t_count CNT_MAX = {CNT_W{1'b1}};

    // Position of the cell in the evaluation stage.
    typedef struct packed {
        logic row_first;
        logic col_first;
        logic row_last;
        logic col_last;
    } t_pos;

endpackage

FILE: rtl/core/lmc_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_line_ram
// Line store with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lmc_line_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read-first: a write in the same cycle is not seen by the read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: rtl/core/lmc_cell_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_cell_eval
// Neighbor compares, 3x3 window registers and the running minimum count.
// ----------------------------------------------------------------------------
module lmc_cell_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_commit,
    input  logic            i_restart,
    input  lmc_pkg::t_pos   i_pos,
    input  lmc_pkg::t_val   i_val,
    input  lmc_pkg::t_val   i_mid_val,
    input  logic            i_mid_flag,
    input  lmc_pkg::t_val   i_right_val,
    input  logic            i_right_flag,
    output logic            o_left_flag,
    output logic            o_cur_flag,
    output lmc_pkg::t_count o_count
);
    import lmc_pkg::*;

    t_val   r_left_val;
    logic   r_left_flag;
    t_val   r_ul_val;
    logic   r_ul_flag;
    t_val   r_um_val;
    logic   r_um_flag;
    t_count r_count;

    t_val   um_val;
    logic   um_flag;
    logic   ul_flag_new;
    logic   um_flag_new;
    logic   ur_flag_new;
    logic   cur;
    logic [2:0]       inc;
    logic [CNT_W:0]   sum;
    t_count n_count;

    always_comb begin
        // At the start of a row the cell above comes straight from the line store.
        um_val  = i_pos.col_first ? i_mid_val  : r_um_val;
        um_flag = i_pos.col_first ? i_mid_flag : r_um_flag;

        ul_flag_new = r_ul_flag    & (r_ul_val    < i_val);
        um_flag_new = um_flag      & (um_val      < i_val);
        ur_flag_new = i_right_flag & (i_right_val < i_val);
        o_left_flag = r_left_flag  & (r_left_val  < i_val);

        cur = 1'b1;
        if (!i_pos.row_first) begin
            if (!i_pos.col_first) begin
                cur = cur & (i_val < r_ul_val);
            end
            cur = cur & (i_val < um_val);
            if (!i_pos.col_last) begin
                cur = cur & (i_val < i_right_val);
            end
        end
        if (!i_pos.col_first) begin
            cur = cur & (i_val < r_left_val);
        end
        o_cur_flag = cur;

        // A flag is counted once its last neighbor has been compared.
        inc = 3'(!i_pos.row_first && !i_pos.col_first && ul_flag_new)
            + 3'(!i_pos.row_first && i_pos.col_last && um_flag_new)
            + 3'(!i_pos.col_first && i_pos.row_last && o_left_flag)
            + 3'(i_pos.row_last && i_pos.col_last && cur);
        sum = {1'b0, r_count} + (CNT_W+1)'(inc);
        n_count = (sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
        o_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_left_val  <= i_val;
            r_left_flag <= cur;
            r_ul_val    <= um_val;
            r_ul_flag   <= um_flag_new;
            r_um_val    <= i_right_val;
            r_um_flag   <= ur_flag_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_count <= '0;
        end else if (i_commit) begin
            if (i_pos.row_last && i_pos.col_last) begin
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: rtl/core/local_minimum_counter_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_minimum_counter_3x3_top
// Counts strict 3x3 local minima of a raster-order frame of signed values.
// ----------------------------------------------------------------------------
// Usage:
//   Cells enter on the slave stream (i_s_*), one signed 32-bit value per item,
//   row by row. Frame size comes from the write port: register 0 is the row
//   count, register 1 the column count; zero acts as one and values above the
//   parameters are clipped. A write restarts the frame in progress.
//   After the last cell of a frame, one item with the minimum count leaves on
//   the master stream (o_m_*) through the evaluation stage and output register.
//   Throughput is one cell per cycle: each cell makes one read of the
//   previous row from the line stores and one write back, with the 3x3
//   window held in registers and same-cycle accesses forwarded.
//   The finished count waits in an output register, so cells keep flowing
//   while it is not taken; the input only stalls when a second frame ends
//   while the first count still waits.
//   Reset returns position, count and sizes (1x1) to their start values.
//   The line stores need no clearing: each entry is written in a frame
//   before it is read.
// ----------------------------------------------------------------------------
module local_minimum_counter_3x3_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg write port
    input  logic                               i_cfg_we,
    input  logic [lmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmc_pkg::CFG_W-1:0]          i_cfg_data,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lmc_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [31:0] cell_value
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [lmc_pkg::OUT_TDATA_W-1:0]    o_m_tdata   // [20:0] minimum_count
);
    import lmc_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CSZ_W = $clog2(MAX_COLS + 1);
    localparam int RSZ_W = $clog2(MAX_ROWS + 1);

    logic [CFG_W-1:0] r_cfg_rows;
    logic [CFG_W-1:0] r_cfg_cols;
    logic [CSZ_W-1:0] cols_eff;
    logic [RSZ_W-1:0] rows_eff;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             pipe_en;
    logic             accept;
    logic             commit;
    logic             s1_end;
    t_pos             pos;
    logic [COL_W-1:0] rd_addr_a;
    logic             rd_a_last;
    logic             rd_b_last;

    // Evaluation stage.
    logic             r_s1_valid;
    t_pos             r_s1_pos;
    t_val             r_s1_val;
    logic [COL_W-1:0] r_s1_col;

    // Forwarding and last-column override marks for the data in flight.
    logic             r_fwd_va;
    logic             r_fwd_vb;
    t_val             r_fwd_val;
    logic             r_fwd_fa;
    logic             r_fwd_fb;
    logic             r_fwd_flag;
    logic             r_ovr_a;
    logic             r_ovr_b;
    logic             r_last_flag;

    logic             flag_we;
    logic [COL_W-1:0] flag_waddr;
    logic             left_flag;
    logic             cur_flag;
    t_count           end_count;

    t_val             rd_val_a;
    t_val             rd_val_b;
    logic             rd_flag_a;
    logic             rd_flag_b;
    t_val             right_val;
    logic             right_flag;
    t_val             mid_val;
    logic             mid_flag;

    logic             r_out_valid;
    t_count           r_out_count;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_W'(1);
            r_cfg_cols <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_ROWS) begin
                r_cfg_rows <= i_cfg_data;
            end
            if (i_cfg_index == REG_FRAME_COLS) begin
                r_cfg_cols <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_cfg_cols == '0) begin
            cols_eff = CSZ_W'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            cols_eff = CSZ_W'(MAX_COLS);
        end else begin
            cols_eff = CSZ_W'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            rows_eff = RSZ_W'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            rows_eff = RSZ_W'(MAX_ROWS);
        end else begin
            rows_eff = RSZ_W'(r_cfg_rows);
        end
    end

    // ------------------------------------------------------------------
    // Input position and read addressing
    // ------------------------------------------------------------------
    assign s1_end     = r_s1_pos.row_last && r_s1_pos.col_last;
    // Hold everything only when a second count would overrun a waiting one.
    assign pipe_en    = !(r_s1_valid && s1_end && r_out_valid && !i_m_tready);
    assign o_s_tready = pipe_en;
    assign accept     = i_s_tvalid && pipe_en;
    assign commit     = r_s1_valid && pipe_en;

    always_comb begin
        pos.row_first = (r_row == '0);
        pos.col_first = (r_col == '0);
        pos.row_last  = ((RSZ_W+1)'(r_row) + (RSZ_W+1)'(1)) == (RSZ_W+1)'(rows_eff);
        pos.col_last  = ((CSZ_W+1)'(r_col) + (CSZ_W+1)'(1)) == (CSZ_W+1)'(cols_eff);
        rd_addr_a     = r_col + COL_W'(1);
        rd_a_last     = ((CSZ_W+1)'(r_col) + (CSZ_W+1)'(2)) == (CSZ_W+1)'(cols_eff);
        rd_b_last     = (cols_eff == CSZ_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (pos.col_last) begin
                r_col <= '0;
                r_row <= pos.row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos   <= pos;
            r_s1_val   <= t_val'(i_s_tdata);
            r_s1_col   <= r_col;
            r_fwd_va   <= commit && (r_s1_col == rd_addr_a);
            r_fwd_vb   <= commit && (r_s1_col == '0);
            r_fwd_val  <= r_s1_val;
            r_fwd_fa   <= flag_we && (flag_waddr == rd_addr_a);
            r_fwd_fb   <= flag_we && (flag_waddr == '0);
            r_fwd_flag <= left_flag;
            r_ovr_a    <= rd_a_last;
            r_ovr_b    <= rd_b_last;
        end
    end

    // The flag of a row's last cell lives here, never in the flag store.
    always_ff @(posedge i_clk) begin
        if (commit && r_s1_pos.col_last) begin
            r_last_flag <= cur_flag;
        end
    end

    // ------------------------------------------------------------------
    // Line stores
    // ------------------------------------------------------------------
    assign flag_we    = commit && !r_s1_pos.col_first;
    assign flag_waddr = r_s1_col - COL_W'(1);

    lmc_line_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS),
        .AW    (COL_W)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_we      (commit),
        .i_waddr   (r_s1_col),
        .i_wdata   (r_s1_val),
        .i_re      (accept),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (COL_W'(0)),
        .o_rdata_a (rd_val_a),
        .o_rdata_b (rd_val_b)
    );

    lmc_line_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS),
        .AW    (COL_W)
    ) u_flag_ram (
        .i_clk     (i_clk),
        .i_we      (flag_we),
        .i_waddr   (flag_waddr),
        .i_wdata   (left_flag),
        .i_re      (accept),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (COL_W'(0)),
        .o_rdata_a (rd_flag_a),
        .o_rdata_b (rd_flag_b)
    );

    always_comb begin
        right_val  = r_fwd_va ? r_fwd_val : rd_val_a;
        mid_val    = r_fwd_vb ? r_fwd_val : rd_val_b;
        right_flag = r_ovr_a ? r_last_flag : (r_fwd_fa ? r_fwd_flag : rd_flag_a);
        mid_flag   = r_ovr_b ? r_last_flag : (r_fwd_fb ? r_fwd_flag : rd_flag_b);
    end

    lmc_cell_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (commit),
        .i_restart    (i_cfg_we),
        .i_pos        (r_s1_pos),
        .i_val        (r_s1_val),
        .i_mid_val    (mid_val),
        .i_mid_flag   (mid_flag),
        .i_right_val  (right_val),
        .i_right_flag (right_flag),
        .o_left_flag  (left_flag),
        .o_cur_flag   (cur_flag),
        .o_count      (end_count)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit && s1_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && s1_end) begin
            r_out_count <= end_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - CNT_W)'(0), r_out_count};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(commit && s1_end && r_out_valid && !i_m_tready))
        else $error("frame count would overrun a waiting result");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CSZ_W+1)'(r_col) < (CSZ_W+1)'(cols_eff))
        else $error("column index beyond frame width");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pos.row_last && pos.col_last |=> (r_col == '0) && (r_row == '0))
        else $error("position did not wrap after the last cell");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && s1_end |=> o_m_tvalid)
        else $error("finished frame gave no result item");

endmodule
